/* src/sem_pkg.sv */
package sem_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_BINARY_MODE    = 2'd0;
  localparam logic [1:0] REG_EDGE_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_IMAGE_WIDTH    = 2'd2;
  localparam logic [1:0] REG_IMAGE_HEIGHT   = 2'd3;

  // Item kinds carried on s_tuser.
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  localparam logic [10:0] EDGE_ON  = 11'd255;
  localparam logic [10:0] EDGE_OFF = 11'd0;

  localparam logic [10:0] RST_THRESHOLD = 11'd128;
  localparam logic [10:0] RST_WIDTH     = 11'd640;
  localparam logic [12:0] RST_HEIGHT    = 13'd480;

  // Magnitude operands and square-root datapath widths.
  localparam int GRAD_W = 11;
  localparam int SQ_W   = 20;
  localparam int ROOT_W = 22;
  localparam int MAG_W  = 11;

  typedef logic signed [GRAD_W-1:0] grad_t;
  typedef logic [MAG_W-1:0] mag_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_GRAD,
    ST_MAG,
    ST_EMIT
  } top_state_t;

  typedef enum logic [2:0] {
    M_IDLE,
    M_SQ,
    M_SUM,
    M_ROOT,
    M_ROUND
  } mag_state_t;

endpackage

/* src/sem_magnitude.sv */
module sem_magnitude (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  sem_pkg::grad_t gx,
  input  sem_pkg::grad_t gy,
  output logic           done,
  output sem_pkg::mag_t  mag
);

  sem_pkg::mag_state_t state, state_next;

  sem_pkg::grad_t gx_r, gy_r;
  logic [sem_pkg::SQ_W-1:0] sqx, sqy;
  logic [sem_pkg::ROOT_W-1:0] rem, res, rbit;
  logic signed [2*sem_pkg::GRAD_W-1:0] px, py;
  logic [sem_pkg::ROOT_W-1:0] trial;
  logic take;

  assign px    = gx_r * gx_r;
  assign py    = gy_r * gy_r;
  assign trial = res + rbit;
  assign take  = rem >= trial;

  always_comb begin
    state_next = state;
    unique case (state)
      sem_pkg::M_IDLE:  if (start) state_next = sem_pkg::M_SQ;
      sem_pkg::M_SQ:    state_next = sem_pkg::M_SUM;
      sem_pkg::M_SUM:   state_next = sem_pkg::M_ROOT;
      sem_pkg::M_ROOT:  if (rbit[0]) state_next = sem_pkg::M_ROUND;
      sem_pkg::M_ROUND: state_next = sem_pkg::M_IDLE;
      default:          state_next = sem_pkg::M_IDLE;
    endcase
  end

  // After the iteration rem holds s - r*r; round to nearest when it exceeds r.
  always_comb begin
    done = (state == sem_pkg::M_ROUND);
    if (rem > res) begin
      mag = sem_pkg::MAG_W'(res + sem_pkg::ROOT_W'(1));
    end else begin
      mag = sem_pkg::MAG_W'(res);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sem_pkg::M_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      sem_pkg::M_IDLE: begin
        if (start) begin
          gx_r <= gx;
          gy_r <= gy;
        end
      end
      sem_pkg::M_SQ: begin
        sqx <= px[sem_pkg::SQ_W-1:0];
        sqy <= py[sem_pkg::SQ_W-1:0];
      end
      sem_pkg::M_SUM: begin
        rem  <= sem_pkg::ROOT_W'(sqx) + sem_pkg::ROOT_W'(sqy);
        res  <= '0;
        // Largest power of four that can fit the sum of two squares.
        rbit <= sem_pkg::ROOT_W'(1) << (sem_pkg::ROOT_W - 2);
      end
      sem_pkg::M_ROOT: begin
        if (take) begin
          rem <= rem - trial;
          res <= (res >> 1) + rbit;
        end else begin
          res <= res >> 1;
        end
        rbit <= rbit >> 2;
      end
      sem_pkg::M_ROUND: begin
      end
      default: begin
      end
    endcase
  end

endmodule

/* src/sobel_edge_magnitude.sv */
// Sobel 3x3 edge magnitude over a raster stream of 8-bit gray pixels.
// One item is handled at a time. An interior pixel's magnitude comes from the
// 11-step square root, and a held output stalls the input. Flushes drain
// pending results; a pixel that arrives mid-drain is dropped.
// Results trail the input by eff_width+1 pixels.
// Synchronous reset restores register defaults and clears counters, not line stores.
module sobel_edge_magnitude #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] gray_pixel
  input  logic        s_tuser,   // [0] req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [10:0] edge_value, [15:11] zero
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [12:0] cfg_data
);

  localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RAW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int PW  = $clog2(MAX_WIDTH + 2);

  // Configuration.
  logic        binary_mode;
  logic [10:0] edge_threshold;
  logic [10:0] image_width;
  logic [12:0] image_height;

  logic [WW-1:0] eff_width;
  logic [HW-1:0] eff_height;

  // Positions and drain bookkeeping.
  logic [AW-1:0]  in_col, out_col;
  logic [RAW-1:0] in_row, out_row;
  logic [PW-1:0]  pending_count;
  logic           draining;

  sem_pkg::top_state_t state, state_next;

  logic [7:0] pixel_r;
  logic [7:0] rd_upper, rd_lower;
  logic [7:0] window_pixels [9];

  logic [7:0] row_store_upper [MAX_WIDTH];
  logic [7:0] row_store_lower [MAX_WIDTH];

  logic [10:0] result;
  logic        result_last;
  logic [10:0] edge_value;
  logic        frame_last;

  logic accept, is_flush, rd_en, wr_en, out_free;
  logic in_col_wrap, in_row_wrap, out_col_wrap, out_row_wrap;
  logic out_border, out_last, need_fill, drain_done;

  sem_pkg::grad_t gx, gy;
  logic [9:0] sx_pos, sx_neg, sy_pos, sy_neg;
  logic       mag_start, mag_done;
  sem_pkg::mag_t mag;

  sem_magnitude u_mag (
    .clk   (clk),
    .rst   (rst),
    .start (mag_start),
    .gx    (gx),
    .gy    (gy),
    .done  (mag_done),
    .mag   (mag)
  );

  always_comb begin
    if (image_width < 11'd3) begin
      eff_width = WW'(3);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      eff_width = WW'(MAX_WIDTH);
    end else begin
      eff_width = WW'(image_width);
    end
    if (image_height < 13'd3) begin
      eff_height = HW'(3);
    end else if (32'(image_height) > 32'(MAX_HEIGHT)) begin
      eff_height = HW'(MAX_HEIGHT);
    end else begin
      eff_height = HW'(image_height);
    end
  end

  assign accept   = s_tvalid && s_tready;
  assign is_flush = (s_tuser == sem_pkg::REQ_FLUSH);
  assign out_free = !m_tvalid || m_tready;

  assign in_col_wrap  = (WW'(in_col) + WW'(1)) >= eff_width;
  assign in_row_wrap  = (HW'(in_row) + HW'(1)) >= eff_height;
  assign out_col_wrap = (WW'(out_col) + WW'(1)) >= eff_width;
  assign out_row_wrap = (HW'(out_row) + HW'(1)) >= eff_height;

  assign out_border = (out_row == '0) || out_row_wrap || (out_col == '0) || out_col_wrap;
  assign out_last   = (HW'(out_row) == eff_height - HW'(1)) &&
                      (WW'(out_col) == eff_width - WW'(1));
  assign need_fill  = pending_count < (PW'(eff_width) + PW'(1));
  assign drain_done = (pending_count == PW'(1));

  // Gradients from the window, which is laid out row by row.
  assign sx_pos = 10'(window_pixels[2]) + {1'b0, window_pixels[5], 1'b0} + 10'(window_pixels[8]);
  assign sx_neg = 10'(window_pixels[0]) + {1'b0, window_pixels[3], 1'b0} + 10'(window_pixels[6]);
  assign sy_pos = 10'(window_pixels[6]) + {1'b0, window_pixels[7], 1'b0} + 10'(window_pixels[8]);
  assign sy_neg = 10'(window_pixels[0]) + {1'b0, window_pixels[1], 1'b0} + 10'(window_pixels[2]);
  assign gx = $signed({1'b0, sx_pos}) - $signed({1'b0, sx_neg});
  assign gy = $signed({1'b0, sy_pos}) - $signed({1'b0, sy_neg});

  always_comb begin
    state_next = state;
    unique case (state)
      sem_pkg::ST_IDLE: begin
        if (accept) begin
          if (is_flush) begin
            if (pending_count != '0) state_next = sem_pkg::ST_EMIT;
          end else if (!draining) begin
            state_next = sem_pkg::ST_UPDATE;
          end
        end
      end
      sem_pkg::ST_UPDATE: begin
        if (need_fill) begin
          state_next = sem_pkg::ST_IDLE;
        end else if (out_border) begin
          state_next = sem_pkg::ST_EMIT;
        end else begin
          state_next = sem_pkg::ST_GRAD;
        end
      end
      sem_pkg::ST_GRAD: state_next = sem_pkg::ST_MAG;
      sem_pkg::ST_MAG:  if (mag_done) state_next = sem_pkg::ST_EMIT;
      sem_pkg::ST_EMIT: if (out_free) state_next = sem_pkg::ST_IDLE;
      default:          state_next = sem_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = (state == sem_pkg::ST_IDLE);
    rd_en     = accept && !is_flush && !draining;
    wr_en     = (state == sem_pkg::ST_UPDATE);
    mag_start = (state == sem_pkg::ST_GRAD);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sem_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Line stores: read at transfer, written back in the following cycle.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_upper <= row_store_upper[in_col];
    end
    if (wr_en) begin
      row_store_upper[in_col] <= rd_lower;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_lower <= row_store_lower[in_col];
    end
    if (wr_en) begin
      row_store_lower[in_col] <= pixel_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      pixel_r <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      binary_mode    <= 1'b0;
      edge_threshold <= sem_pkg::RST_THRESHOLD;
      image_width    <= sem_pkg::RST_WIDTH;
      image_height   <= sem_pkg::RST_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        sem_pkg::REG_BINARY_MODE:    binary_mode    <= cfg_data[0];
        sem_pkg::REG_EDGE_THRESHOLD: edge_threshold <= cfg_data[10:0];
        sem_pkg::REG_IMAGE_WIDTH:    image_width    <= cfg_data[10:0];
        sem_pkg::REG_IMAGE_HEIGHT:   image_height   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        window_pixels[i] <= '0;
      end
      in_col        <= '0;
      in_row        <= '0;
      out_col       <= '0;
      out_row       <= '0;
      pending_count <= '0;
      draining      <= 1'b0;
    end else begin
      if (state == sem_pkg::ST_IDLE && accept && is_flush) begin
        if (pending_count == '0) begin
          draining <= 1'b0;
        end else begin
          pending_count <= pending_count - PW'(1);
          if (drain_done) begin
            // Last pending result leaves: the next pixel starts a new frame.
            draining <= 1'b0;
            in_col   <= '0;
            in_row   <= '0;
            out_col  <= '0;
            out_row  <= '0;
          end else begin
            draining <= 1'b1;
            if (out_col_wrap) begin
              out_col <= '0;
              out_row <= out_row_wrap ? '0 : out_row + RAW'(1);
            end else begin
              out_col <= out_col + AW'(1);
            end
          end
        end
      end
      if (state == sem_pkg::ST_UPDATE) begin
        for (int r = 0; r < 3; r++) begin
          window_pixels[r*3]   <= window_pixels[r*3+1];
          window_pixels[r*3+1] <= window_pixels[r*3+2];
        end
        window_pixels[2] <= rd_upper;
        window_pixels[5] <= rd_lower;
        window_pixels[8] <= pixel_r;
        if (in_col_wrap) begin
          in_col <= '0;
          in_row <= in_row_wrap ? '0 : in_row + RAW'(1);
        end else begin
          in_col <= in_col + AW'(1);
        end
        if (need_fill) begin
          pending_count <= pending_count + PW'(1);
        end else if (out_col_wrap) begin
          out_col <= '0;
          out_row <= out_row_wrap ? '0 : out_row + RAW'(1);
        end else begin
          out_col <= out_col + AW'(1);
        end
      end
    end
  end

  // Result staging: the flag is taken from the output counters before they move.
  always_ff @(posedge clk) begin
    if (state == sem_pkg::ST_IDLE && accept && is_flush) begin
      result      <= sem_pkg::EDGE_OFF;
      result_last <= out_last;
    end
    if (state == sem_pkg::ST_UPDATE) begin
      result      <= sem_pkg::EDGE_OFF;
      result_last <= out_last;
    end
    if (state == sem_pkg::ST_MAG && mag_done) begin
      if (binary_mode) begin
        result <= (mag <= edge_threshold) ? sem_pkg::EDGE_OFF : sem_pkg::EDGE_ON;
      end else begin
        result <= mag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == sem_pkg::ST_EMIT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == sem_pkg::ST_EMIT && out_free) begin
      edge_value <= result;
      frame_last <= result_last;
    end
  end

  assign m_tdata = {5'b0, edge_value};
  assign m_tlast = frame_last;

endmodule

/* dv/sobel_edge_magnitude_checker.sv */
`timescale 1ns / 100ps

module sobel_edge_magnitude_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] gray_pixel
  input  logic        s_tuser,   // [0] req_type
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // [10:0] edge_value, [15:11] zero
  input  logic        m_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [12:0] cfg_data,
  output int          mismatches,
  output int          waiting,
  output bit          pipe_empty
);

  localparam int unsigned LINE_MAX  = 1024;
  localparam int unsigned FRAME_MAX = 4096;

  typedef struct packed {
    logic [10:0] edge_value;
    logic        frame_last;
  } edge_result_t;

  edge_result_t edge_queue[$];

  // Shadow of the block's registers.
  logic        bin_mode;
  logic [10:0] thresh;
  logic [10:0] width_reg;
  logic [12:0] height_reg;

  // Shadow of the block's stream state.
  logic [7:0]  upper_line [LINE_MAX];
  logic [7:0]  lower_line [LINE_MAX];
  logic [7:0]  win [9];
  int unsigned in_col, in_row, out_col, out_row, pend;
  bit          draining;

  function automatic int unsigned eff_width();
    if (width_reg < 3) return 3;
    if (width_reg > LINE_MAX) return LINE_MAX;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    if (height_reg < 3) return 3;
    if (height_reg > FRAME_MAX) return FRAME_MAX;
    return height_reg;
  endfunction

  function automatic logic [10:0] window_edge();
    int          gx, gy;
    int unsigned sq, root;
    gx = (int'(win[2]) + 2 * int'(win[5]) + int'(win[8]))
       - (int'(win[0]) + 2 * int'(win[3]) + int'(win[6]));
    gy = (int'(win[6]) + 2 * int'(win[7]) + int'(win[8]))
       - (int'(win[0]) + 2 * int'(win[1]) + int'(win[2]));
    sq = gx * gx + gy * gy;
    // Start from the real root, correct it to the exact integer floor, then round to nearest.
    root = $rtoi($sqrt(real'(sq)));
    while (root * root > sq) root--;
    while ((root + 1) * (root + 1) <= sq) root++;
    if (sq - root * root > root) root++;
    if (bin_mode) return (root <= thresh) ? sem_pkg::EDGE_OFF : sem_pkg::EDGE_ON;
    return root[10:0];
  endfunction

  task automatic step_pos(inout int unsigned col, inout int unsigned row);
    if (col + 1 >= eff_width()) begin
      col = 0;
      if (row + 1 >= eff_height()) row = 0;
      else row++;
    end else begin
      col++;
    end
  endtask

  task automatic emit_edge(input bit drained);
    int unsigned  w, h;
    bit           border;
    edge_result_t res;
    w = eff_width();
    h = eff_height();
    border = out_row == 0 || out_row + 1 >= h || out_col == 0 || out_col + 1 >= w;
    res.edge_value = (border || drained) ? sem_pkg::EDGE_OFF : window_edge();
    res.frame_last = (out_row == h - 1 && out_col == w - 1);
    edge_queue.push_back(res);
    step_pos(out_col, out_row);
  endtask

  task automatic sobel_step(input logic kind, input logic [7:0] pix);
    int unsigned idx;
    logic [7:0]  top_px, mid_px;
    if (kind == sem_pkg::REQ_FLUSH) begin
      if (pend == 0) begin
        draining = 1'b0;
      end else begin
        draining = 1'b1;
        emit_edge(1'b1);
        pend--;
        if (pend == 0) begin
          // Drain is over: the next pixel opens a new frame.
          draining = 1'b0;
          in_col = 0;
          in_row = 0;
          out_col = 0;
          out_row = 0;
        end
      end
    end else if (!draining) begin
      idx = (in_col < LINE_MAX) ? in_col : LINE_MAX - 1;
      top_px = upper_line[idx];
      mid_px = lower_line[idx];
      for (int r = 0; r < 3; r++) begin
        win[r * 3]     = win[r * 3 + 1];
        win[r * 3 + 1] = win[r * 3 + 2];
      end
      win[2] = top_px;
      win[5] = mid_px;
      win[8] = pix;
      upper_line[idx] = mid_px;
      lower_line[idx] = pix;
      step_pos(in_col, in_row);
      if (pend < eff_width() + 1) pend++;
      else emit_edge(1'b0);
    end
  endtask

  task automatic note_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_result();
    edge_result_t want;
    if (edge_queue.size() == 0) begin
      note_mismatch($sformatf("unexpected result tdata %h tlast %b", m_tdata, m_tlast));
    end else begin
      want = edge_queue.pop_front();
      if (m_tdata !== {5'd0, want.edge_value})
        note_mismatch($sformatf("edge_value got %0d (tdata %h) expected %0d",
                                m_tdata[10:0], m_tdata, want.edge_value));
      if (m_tlast !== want.frame_last)
        note_mismatch($sformatf("frame_last got %b expected %b", m_tlast, want.frame_last));
    end
  endtask

  initial begin
    mismatches = 0;
    waiting = 0;
    pipe_empty = 1'b1;
  end

  always @(posedge clk) begin
    if (rst) begin
      bin_mode = 1'b0;
      thresh = sem_pkg::RST_THRESHOLD;
      width_reg = sem_pkg::RST_WIDTH;
      height_reg = sem_pkg::RST_HEIGHT;
      for (int i = 0; i < LINE_MAX; i++) begin
        upper_line[i] = 8'd0;
        lower_line[i] = 8'd0;
      end
      for (int i = 0; i < 9; i++) win[i] = 8'd0;
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
      pend = 0;
      draining = 1'b0;
      edge_queue.delete();
    end else begin
      // A result can never come from an item accepted at the same edge.
      if (m_tvalid && m_tready) check_result();
      if (s_tvalid && s_tready) sobel_step(s_tuser, s_tdata);
      if (cfg_we) begin
        case (cfg_addr)
          sem_pkg::REG_BINARY_MODE:    bin_mode = cfg_data[0];
          sem_pkg::REG_EDGE_THRESHOLD: thresh = cfg_data[10:0];
          sem_pkg::REG_IMAGE_WIDTH:    width_reg = cfg_data[10:0];
          sem_pkg::REG_IMAGE_HEIGHT:   height_reg = cfg_data[12:0];
          default: ;
        endcase
      end
    end
    waiting = edge_queue.size();
    pipe_empty = (pend == 0);
  end

endmodule

/* dv/sobel_edge_magnitude_test.sv */
`timescale 1ns / 100ps

module sobel_edge_magnitude_test;

  localparam int          QUIET_LIMIT = 4000;
  localparam int unsigned RANDOM_ITEMS = 800;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned STALL_AT = 200;
  localparam int unsigned STALL_CYCLES = 500;
  localparam int unsigned WIDE_ITEMS = 1080;

  // Directed 3x3 frames, first pixel in the lowest byte.
  localparam logic [71:0] LEFT_EDGE  = {8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255,
                                        8'd0, 8'd0, 8'd255};
  localparam logic [71:0] RIGHT_EDGE = {8'd255, 8'd255, 8'd0, 8'd255, 8'd0, 8'd0,
                                        8'd255, 8'd0, 8'd0};

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] gray_pixel
  logic        s_tuser;   // [0] req_type
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // [10:0] edge_value, [15:11] zero
  logic        m_tlast;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [12:0] cfg_data;

  int          mismatches;
  int          waiting;
  bit          pipe_empty;

  bit          no_gaps;
  int unsigned items_sent;
  int unsigned results_taken;
  int unsigned settings_used;
  int unsigned random_items;
  int          quiet;

  sobel_edge_magnitude uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  sobel_edge_magnitude_checker chk (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .waiting    (waiting),
    .pipe_empty (pipe_empty)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int unsigned clamp_size(input int unsigned v, input int unsigned hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [7:0] rand_pixel();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_item(input logic kind, input logic [7:0] pix);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = kind;
    s_tdata = pix;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_frame3(input logic [71:0] pixels);
    for (int i = 0; i < 9; i++) send_item(sem_pkg::REQ_PIXEL, pixels[8 * i +: 8]);
  endtask

  // Registers may only change once every outstanding result is out and the
  // last item has had time to finish inside the block.
  task automatic settle();
    s_tvalid = 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_data = val;
    @(negedge clk);
  endtask

  task automatic set_config(input logic bm, input logic [12:0] thr,
                            input logic [12:0] wid, input logic [12:0] hgt);
    write_reg(sem_pkg::REG_BINARY_MODE, {12'd0, bm});
    write_reg(sem_pkg::REG_EDGE_THRESHOLD, thr);
    write_reg(sem_pkg::REG_IMAGE_WIDTH, wid);
    write_reg(sem_pkg::REG_IMAGE_HEIGHT, hgt);
    cfg_we = 1'b0;
    settings_used++;
  endtask

  // Flush until nothing is pending, with an occasional pixel that the block
  // must drop because a drain is under way.
  task automatic drain_stream();
    bit started;
    started = 1'b0;
    while (!pipe_empty) begin
      if (started && $urandom_range(0, 9) == 0) begin
        send_item(sem_pkg::REQ_PIXEL, rand_pixel());
      end else begin
        send_item(sem_pkg::REQ_FLUSH, rand_pixel());
        started = 1'b1;
      end
    end
    if ($urandom_range(0, 3) == 0) send_item(sem_pkg::REQ_FLUSH, rand_pixel());
  endtask

  task automatic random_phase();
    int unsigned r, w, h, n;
    logic [12:0] wv, hv, tv;
    settle();
    r = $urandom_range(0, 99);
    if (r < 4) wv = 13'($urandom_range(0, 2));
    else wv = 13'($urandom_range(3, 12));
    r = $urandom_range(0, 99);
    if (r < 4) hv = 13'($urandom_range(0, 2));
    else if (r < 6) hv = 13'd8191;
    else if (r < 8) hv = 13'd4096;
    else hv = 13'($urandom_range(3, 9));
    r = $urandom_range(0, 99);
    if (r < 10) tv = 13'd0;
    else if (r < 20) tv = 13'd2047;
    else if (r < 25) tv = 13'd1443;
    else tv = 13'($urandom_range(0, 600));
    set_config(1'($urandom_range(0, 1)), tv, wv, hv);
    w = clamp_size(wv, 1024);
    h = clamp_size(hv, 4096);
    no_gaps = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 4) != 0) begin
      // One to three whole frames, or 20 to 400 pixels; maybe a partial row.
      n = w * h * $urandom_range(1, 3);
      if (n > 400) n = $urandom_range(20, 400);
      else if ($urandom_range(0, 2) == 0) n += $urandom_range(0, w);
      repeat (n) send_item(sem_pkg::REQ_PIXEL, rand_pixel());
      random_items += n;
      if ($urandom_range(0, 9) < 7) drain_stream();
    end else begin
      n = $urandom_range(10, 60);
      repeat (n) send_item(($urandom_range(0, 3) == 0) ? sem_pkg::REQ_FLUSH
                                                       : sem_pkg::REQ_PIXEL,
                           rand_pixel());
      random_items += n;
      if ($urandom_range(0, 1) == 0) drain_stream();
    end
  endtask

  initial begin : result_sink
    int unsigned gap;
    bit          held;
    m_tready = 1'b0;
    held = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      // One long hold-off so the block fills and stalls its input.
      if (!held && results_taken == STALL_AT) begin
        held = 1'b1;
        m_tready = 1'b0;
        repeat (STALL_CYCLES) @(negedge clk);
      end
      gap = no_gaps ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
        m_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready = 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      results_taken++;
      @(negedge clk);
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tuser = sem_pkg::REQ_PIXEL;
    s_tdata = 8'd0;
    cfg_we = 1'b0;
    cfg_addr = sem_pkg::REG_BINARY_MODE;
    cfg_data = 13'd0;
    no_gaps = 1'b0;
    items_sent = 0;
    results_taken = 0;
    settings_used = 0;
    random_items = 0;
    quiet = 0;
    repeat (9) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Smallest frame, raw magnitude: start of output, one flush, a pixel
    // dropped in mid-drain, the end of the frame and a flush with nothing left.
    set_config(1'b0, 13'd128, 13'd3, 13'd3);
    send_frame3(RIGHT_EDGE);
    send_item(sem_pkg::REQ_FLUSH, 8'd0);
    send_item(sem_pkg::REQ_PIXEL, 8'h5A);
    repeat (3) send_item(sem_pkg::REQ_FLUSH, 8'hFF);
    send_item(sem_pkg::REQ_FLUSH, 8'd0);

    // Binary mode, then a shrink of the height while the input row sits
    // beyond the new size; a zero height clamps to the minimum.
    settle();
    set_config(1'b1, 13'd0, 13'd3, 13'd5);
    send_frame3(LEFT_EDGE);
    settle();
    write_reg(sem_pkg::REG_IMAGE_HEIGHT, 13'd0);
    write_reg(sem_pkg::REG_EDGE_THRESHOLD, 13'd2047);
    cfg_we = 1'b0;
    send_item(sem_pkg::REQ_PIXEL, 8'hFF);
    send_item(sem_pkg::REQ_PIXEL, 8'd0);
    drain_stream();

    // Two full rows at width 12, the widest that random phases use, so every
    // line-store entry they can reach holds written data before any
    // mid-frame size change.
    settle();
    set_config(1'b0, 13'd128, 13'd12, 13'd3);
    repeat (24) send_item(sem_pkg::REQ_PIXEL, rand_pixel());
    drain_stream();

    while (random_items < RANDOM_ITEMS) random_phase();

    // An oversized width clamps to 1024: starting from a fresh frame, results
    // appear only after one full line plus one pixel.
    settle();
    drain_stream();
    settle();
    set_config(1'b0, 13'd128, 13'd2047, 13'd3);
    repeat (WIDE_ITEMS) send_item(sem_pkg::REQ_PIXEL, rand_pixel());

    s_tvalid = 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (SETTLE_CYCLES + 6) @(negedge clk);

    $display("Sent %0d input transfers and checked %0d results over %0d register settings.",
             items_sent, results_taken, settings_used);
    $display("Covered raw and binary modes, a clamped full-width line, clamped sizes,"
             , " mid-frame size changes, drains and a long output stall.");
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* sim.f */
src/sem_pkg.sv
src/sem_magnitude.sv
src/sobel_edge_magnitude.sv
dv/sobel_edge_magnitude_checker.sv
dv/sobel_edge_magnitude_test.sv
